// File: src/bpc_pkg.sv
package bpc_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned IndexWidth = 2;
   localparam int unsigned ReqWidth   = 40;
   localparam int unsigned RspWidth   = 8;

   // register indexes on the csr channel
   localparam logic [IndexWidth-1:0] RegDebounce  = 2'd0;
   localparam logic [IndexWidth-1:0] RegLongPress = 2'd1;
   localparam logic [IndexWidth-1:0] RegClickMin  = 2'd2;

   localparam logic [CfgWidth-1:0] DebounceReset  = 16'd50;
   localparam logic [CfgWidth-1:0] LongPressReset = 16'd1000;
   localparam logic [CfgWidth-1:0] ClickMinReset  = 16'd50;

   typedef struct packed {
      logic [CfgWidth-1:0] debounce_ms;
      logic [CfgWidth-1:0] long_press_ms;
      logic [CfgWidth-1:0] click_min_ms;
   } cfg_type;

   typedef struct packed {
      logic button_stable;
      logic long_press;
      logic short_click;
   } result_type;

endpackage

// File: src/bpc_csr.sv
module bpc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bpc_pkg::IndexWidth-1:0]    csr_index,
   input  logic [bpc_pkg::CfgWidth-1:0]      csr_data,
   output bpc_pkg::cfg_type                  cfg
);

   bpc_pkg::cfg_type cfg_ff;
   bpc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bpc_pkg::RegDebounce:  cfg_in.debounce_ms   = csr_data;
            bpc_pkg::RegLongPress: cfg_in.long_press_ms = csr_data;
            bpc_pkg::RegClickMin:  cfg_in.click_min_ms  = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= bpc_pkg::DebounceReset;
         cfg_ff.long_press_ms <= bpc_pkg::LongPressReset;
         cfg_ff.click_min_ms  <= bpc_pkg::ClickMinReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/bpc_track.sv
module bpc_track (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [bpc_pkg::TimeWidth-1:0]    now_ms,
   input  logic                             button_raw,
   input  bpc_pkg::cfg_type                 cfg,
   output bpc_pkg::result_type              result
);

   logic                           last_raw_ff, last_raw_in;
   logic                           stable_ff, stable_in;
   logic [bpc_pkg::TimeWidth-1:0]  change_time_ff, change_time_in;
   logic [bpc_pkg::TimeWidth-1:0]  press_start_ff, press_start_in;
   logic                           active_ff, active_in;
   logic                           long_done_ff, long_done_in;

   logic [bpc_pkg::TimeWidth-1:0]  since_change;
   logic [bpc_pkg::TimeWidth-1:0]  held;
   logic                           raw_changed;
   logic                           settled;
   logic                           held_long;
   logic                           held_click;
   logic                           clk_flag;
   logic                           lng_flag;

   assign raw_changed = (button_raw != last_raw_ff);
   // a fresh raw edge restarts the timer at this sample, so elapsed is zero
   assign since_change = raw_changed ? '0 : (now_ms - change_time_ff);
   assign settled = (since_change >= {16'd0, cfg.debounce_ms}) && (button_raw != stable_ff);
   assign held = now_ms - press_start_ff;
   assign held_long  = (held >= {16'd0, cfg.long_press_ms});
   assign held_click = (held >= {16'd0, cfg.click_min_ms});

   always_comb begin
      last_raw_in    = button_raw;
      change_time_in = raw_changed ? now_ms : change_time_ff;
      stable_in      = stable_ff;
      press_start_in = press_start_ff;
      active_in      = active_ff;
      long_done_in   = long_done_ff;
      clk_flag       = 1'b0;
      lng_flag       = 1'b0;
      if (settled) begin
         stable_in = button_raw;
         if (button_raw) begin
            press_start_in = now_ms;
            active_in      = 1'b1;
            long_done_in   = 1'b0;
            // hold starts now: long only when the threshold is zero
            if (cfg.long_press_ms == '0) begin
               lng_flag     = 1'b1;
               long_done_in = 1'b1;
            end
         end else begin
            if (!long_done_ff) begin
               if (held_long) begin
                  lng_flag = 1'b1;
               end else if (held_click) begin
                  clk_flag = 1'b1;
               end
            end
            press_start_in = '0;
            active_in      = 1'b0;
            long_done_in   = 1'b0;
         end
      end else if (stable_ff && active_ff && !long_done_ff && held_long) begin
         lng_flag     = 1'b1;
         long_done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         change_time_ff <= '0;
         press_start_ff <= '0;
         active_ff      <= 1'b0;
         long_done_ff   <= 1'b0;
      end else if (step) begin
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
         press_start_ff <= press_start_in;
         active_ff      <= active_in;
         long_done_ff   <= long_done_in;
      end
   end

   assign result.short_click   = clk_flag;
   assign result.long_press    = lng_flag;
   assign result.button_stable = stable_in;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(result.short_click && result.long_press))
      else $error("short click and long press on one item");

   a_long_done_in_press: assert property (@(posedge clock) disable iff (reset)
      long_done_ff |-> (active_ff && stable_ff))
      else $error("long press marked outside a press");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      $fell(stable_ff) |-> (!active_ff && !long_done_ff && press_start_ff == '0))
      else $error("press state left over after release");

   a_long_once: assert property (@(posedge clock) disable iff (reset)
      (step && result.long_press && stable_in) |=> long_done_ff)
      else $error("long press during hold not recorded");

endmodule

// File: src/button_press_classifier_core.sv
// Push button classifier: debounce plus short click / long press detection.
//
// req channel: one sample per item (now_ms in req_tdata[31:0], button_raw in
// req_tdata[32]). rsp channel: exactly one result per sample, giving
// short_click, long_press and the debounced level button_stable.
// csr channel: index 0 debounce_ms, 1 long_press_ms, 2 click_min_ms (16 bit);
// other indexes are dropped. Write only while no sample is in flight.
//
// Throughput: one sample per cycle; the input register feeds the tracker
// and its result register, both advancing together whenever the result
// register is empty or being drained.
// Stall: when rsp_tready is low the result holds in the output register and
// one further sample waits in the input register; req_tready then drops.
// Reset: thresholds return to 50 / 1000 / 50 ms, the button reads released
// and both registers empty.
module button_press_classifier_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bpc_pkg::ReqWidth-1:0]       req_tdata,   // now_ms[31:0], button_raw[32]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bpc_pkg::RspWidth-1:0]       rsp_tdata,   // short_click, long_press,
                                                           // button_stable
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bpc_pkg::IndexWidth-1:0]     csr_index,
   input  logic [bpc_pkg::CfgWidth-1:0]       csr_data
);

   bpc_pkg::cfg_type               cfg;
   bpc_pkg::result_type            result;

   logic                           in_valid_ff;
   logic [bpc_pkg::TimeWidth-1:0]  now_ff;
   logic                           raw_ff;
   logic                           out_valid_ff;
   bpc_pkg::result_type            out_ff;
   logic                           advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         now_ff <= req_tdata[bpc_pkg::TimeWidth-1:0];
         raw_ff <= req_tdata[bpc_pkg::TimeWidth];
      end
   end

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bpc_track u_track (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .now_ms     (now_ff),
      .button_raw (raw_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.button_stable, out_ff.long_press, out_ff.short_click};

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("result changed while stalled");

   a_no_step_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !advance)
      else $error("tracker advanced into a full result register");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("item taken with both registers full");

endmodule

// File: sim/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpc_pkg::*;

   localparam logic [IndexWidth-1:0] RegNone = 2'd3;
   localparam int unsigned IdleLimit = 2000;
   localparam int unsigned ItemsPerPhase = 72;

   typedef struct {
      logic [TimeWidth-1:0] now_ms;
      logic                 button_raw;
   } sample_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqWidth-1:0]    req_tdata = '0;   // now_ms[31:0], button_raw[32]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspWidth-1:0]    rsp_tdata;        // short_click, long_press, button_stable
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [IndexWidth-1:0]  csr_index = '0;
   logic [CfgWidth-1:0]    csr_data = '0;

   button_press_classifier_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // classifier state as seen by the testbench
   cfg_type              thresholds = '{DebounceReset, LongPressReset, ClickMinReset};
   logic                 raw_seen = 1'b0;
   logic                 level = 1'b0;
   logic [TimeWidth-1:0] raw_change_ms = '0;
   logic [TimeWidth-1:0] press_t0 = '0;
   logic                 pressed = 1'b0;
   logic                 long_seen = 1'b0;

   sample_type           samples_q[$];
   result_type           outcome_q[$];
   sample_type           on_wire;
   logic [TimeWidth-1:0] stamp = '0;

   int unsigned errors = 0;
   int unsigned sent = 0;
   int unsigned results = 0;
   int unsigned clicks = 0;
   int unsigned longs = 0;
   int unsigned settings = 0;
   int unsigned queued = 0;

   function automatic result_type classify_sample(input logic [TimeWidth-1:0] now,
                                                  input logic raw);
      result_type           r;
      logic [TimeWidth-1:0] since_change;
      logic [TimeWidth-1:0] held;
      r = '0;
      if (raw != raw_seen) begin
         raw_seen = raw;
         raw_change_ms = now;
      end
      since_change = now - raw_change_ms;
      if (since_change >= TimeWidth'(thresholds.debounce_ms) && raw != level) begin
         level = raw;
         if (level) begin
            press_t0 = now;
            pressed = 1'b1;
            long_seen = 1'b0;
         end else begin
            if (!long_seen) begin
               held = now - press_t0;
               if (held >= TimeWidth'(thresholds.long_press_ms)) begin
                  r.long_press = 1'b1;
               end else if (held >= TimeWidth'(thresholds.click_min_ms)) begin
                  r.short_click = 1'b1;
               end
            end
            press_t0 = '0;
            pressed = 1'b0;
            long_seen = 1'b0;
         end
      end
      held = now - press_t0;
      if (level && pressed && !long_seen && held >= TimeWidth'(thresholds.long_press_ms)) begin
         r.long_press = 1'b1;
         long_seen = 1'b1;
      end
      r.button_stable = level;
      return r;
   endfunction

   // sample driver
   int unsigned req_gap = 0;
   logic        req_calm = 1'b0;
   result_type  predicted;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = classify_sample(on_wire.now_ms, on_wire.button_raw);
            outcome_q.push_back(predicted);
            sent++;
            clicks += predicted.short_click;
            longs += predicted.long_press;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (samples_q.size() != 0) begin
               on_wire = samples_q.pop_front();
               req_tdata <= {{(ReqWidth - TimeWidth - 1){1'b0}}, on_wire.button_raw,
                             on_wire.now_ms};
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
               req_gap <= req_calm ? 0 : $urandom_range(0, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   int unsigned rsp_hold = 0;
   int unsigned rsp_draw;
   logic        rsp_calm = 1'b0;
   result_type  got;
   result_type  want;

   task automatic check_flag(input string name, input logic exp_bit, input logic act_bit);
      if (exp_bit !== act_bit) begin
         errors++;
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp_bit, act_bit);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[2:0];
         results++;
         if (outcome_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %b", $time, rsp_tdata);
         end else begin
            want = outcome_q.pop_front();
            check_flag("short_click", want.short_click, got.short_click);
            check_flag("long_press", want.long_press, got.long_press);
            check_flag("button_stable", want.button_stable, got.button_stable);
         end
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         rsp_draw = rsp_calm ? 0 : $urandom_range(0, 13);
         if (rsp_draw == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rsp_hold <= rsp_draw - 1;
         end
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: end the run if nothing moves for too long
   int unsigned quiet = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= IdleLimit) begin
         $display("%0t: no progress for %0d cycles", $time, IdleLimit);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic add_sample(input logic [TimeWidth-1:0] now, input logic raw);
      samples_q.push_back('{now, raw});
      queued++;
   endtask

   // hold until every queued item has been taken and answered
   task automatic wait_drained();
      while (sent != queued || results != sent) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [IndexWidth-1:0] idx, input logic [CfgWidth-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         RegDebounce:  thresholds.debounce_ms = val;
         RegLongPress: thresholds.long_press_ms = val;
         RegClickMin:  thresholds.click_min_ms = val;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [CfgWidth-1:0] db, input logic [CfgWidth-1:0] lp,
                                input logic [CfgWidth-1:0] cm);
      wait_drained();
      write_reg(RegClickMin, cm);
      if ($urandom_range(0, 1)) write_reg(RegNone, CfgWidth'($urandom));
      write_reg(RegDebounce, db);
      write_reg(RegLongPress, lp);
      settings++;
   endtask

   // contact bounce ending on a clean edge to lvl at t_end
   task automatic bounce_to(input logic lvl, input logic [TimeWidth-1:0] t_end);
      int unsigned          n;
      logic [TimeWidth-1:0] s;
      n = $urandom_range(0, 3);
      s = $urandom_range(1, (thresholds.debounce_ms > 4) ? thresholds.debounce_ms / 4 : 1);
      for (int j = n; j > 0; j--) begin
         add_sample(t_end - 2 * j * s, lvl);
         add_sample(t_end - 2 * j * s + s, !lvl);
      end
      add_sample(t_end, lvl);
   endtask

   // one press: bounce, a few hold samples, bounce back, then in most cases a settled release
   task automatic press_gesture();
      logic [TimeWidth-1:0] db, lp, cm, t0, dur, off;
      int unsigned          m;
      db = TimeWidth'(thresholds.debounce_ms);
      lp = TimeWidth'(thresholds.long_press_ms);
      cm = TimeWidth'(thresholds.click_min_ms);
      t0 = stamp + 2 * db + $urandom_range(7, 200);
      bounce_to(1'b1, t0);
      add_sample(t0 + db, 1'b1);
      case ($urandom_range(0, 5))
         0: dur = (cm != 0) ? cm - 1 : 0;
         1: dur = cm;
         2: dur = (lp != 0) ? lp - 1 : 0;
         3: dur = lp;
         4: dur = $urandom_range(0, lp + lp / 2 + 2);
         default: dur = $urandom_range(0, cm + 1);
      endcase
      if (lp < dur && $urandom_range(0, 1)) add_sample(t0 + db + lp, 1'b1);
      m = $urandom_range(0, 4);
      for (int i = 0; i < m; i++) begin
         off = TimeWidth'((longint'(dur) * (i + 1)) / (m + 1));
         add_sample(t0 + db + off, 1'b1);
      end
      bounce_to(1'b0, t0 + dur);
      if ($urandom_range(0, 7) != 0) add_sample(t0 + dur + db, 1'b0);
      stamp = t0 + dur + db + $urandom_range(1, 50);
   endtask

   task automatic noise_burst();
      int unsigned n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 2))
            0: add_sample($urandom, 1'($urandom));
            1: add_sample(stamp - $urandom_range(1, 1000), 1'($urandom));
            default: begin
               stamp = stamp + $urandom_range(0, 70000);
               add_sample(stamp, 1'($urandom));
            end
         endcase
      end
   endtask

   task automatic random_phase(input logic [CfgWidth-1:0] db, input logic [CfgWidth-1:0] lp,
                               input logic [CfgWidth-1:0] cm);
      int unsigned goal;
      apply_setting(db, lp, cm);
      goal = queued + ItemsPerPhase;
      while (queued < goal) begin
         if ($urandom_range(0, 4) != 0) press_gesture();
         else noise_burst();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: field extremes with a release-time long press, a click, a held long press
      add_sample(32'h0000_0000, 1'b0);
      add_sample(32'hFFFF_FFFF, 1'b1);
      add_sample(32'h0000_0031, 1'b1);
      add_sample(32'h0000_0032, 1'b1);
      add_sample(32'h0000_0400, 1'b0);
      add_sample(32'h0000_0432, 1'b0);
      add_sample(32'h0000_0464, 1'b1);
      add_sample(32'h0000_0496, 1'b1);
      add_sample(32'h0000_04C8, 1'b0);
      add_sample(32'h0000_04FA, 1'b0);
      add_sample(32'h0000_07D0, 1'b1);
      add_sample(32'h0000_0802, 1'b1);
      add_sample(32'h0000_0BE9, 1'b1);
      add_sample(32'h0000_0BEA, 1'b1);
      add_sample(32'h0000_0C1C, 1'b0);
      add_sample(32'h0000_0C4E, 1'b0);

      // zero debounce and zero hold time, then time running backwards
      apply_setting('0, '0, '0);
      add_sample(32'h0000_1000, 1'b1);
      add_sample(32'h0000_1001, 1'b1);
      add_sample(32'h0000_1002, 1'b0);
      add_sample(32'h0000_0800, 1'b1);
      add_sample(32'h0000_0700, 1'b0);

      // zero debounce with a nonzero hold time: two release-time long presses
      apply_setting('0, 16'd300, 16'd100);
      add_sample(32'h0000_2000, 1'b1);
      add_sample(32'h0000_2200, 1'b0);
      add_sample(32'h0000_2300, 1'b1);
      add_sample(32'h0000_2500, 1'b0);
      stamp = 32'h0000_3000;

      random_phase(DebounceReset, LongPressReset, ClickMinReset);
      random_phase('0, 16'd300, 16'd100);
      stamp = 32'hFFFF_FC00;
      random_phase(16'd5, 16'd40, 16'd10);
      random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(16'd20, 16'd100, 16'd200);
      random_phase(16'd3, 16'hFFFF, '0);
      random_phase(CfgWidth'($urandom), CfgWidth'($urandom), CfgWidth'($urandom));
      random_phase(CfgWidth'($urandom_range(0, 40)), CfgWidth'($urandom_range(0, 400)),
                   CfgWidth'($urandom_range(0, 100)));

      wait_drained();
      repeat (4) @(posedge clock);

      $display("Classified %0d button samples over %0d threshold settings:", sent, settings);
      $display("%0d results checked, %0d short clicks and %0d long presses expected.",
               results, clicks, longs);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
src/bpc_pkg.sv
src/bpc_csr.sv
src/bpc_track.sv
src/button_press_classifier_core.sv
sim/tb_top.sv
